[hdl/bgd_pkg.sv]
// Package for the button gesture detector: widths, codes, register map and config type.
`timescale 1ns / 1ps

package bgd_pkg;

    // Payload and register widths
    localparam int unsigned GestureW  = 2;
    localparam int unsigned DebounceW = 8;
    localparam int unsigned TimerW    = 16;
    localparam int unsigned TapW      = 2;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 16;

    // Gesture codes
    localparam logic [GestureW-1:0] GEST_NONE   = 2'd0;
    localparam logic [GestureW-1:0] GEST_LONG   = 2'd1;
    localparam logic [GestureW-1:0] GEST_DOUBLE = 2'd2;
    localparam logic [GestureW-1:0] GEST_TRIPLE = 2'd3;

    // Register indexes
    localparam logic [CfgIdxW-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_LONG     = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_DOUBLE   = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_TRIPLE   = 2'd3;

    // Register reset values
    localparam logic [DebounceW-1:0] DEBOUNCE_RST = 8'd30;
    localparam logic [TimerW-1:0]    LONG_RST     = 16'd1000;
    localparam logic [TimerW-1:0]    DOUBLE_RST   = 16'd400;
    localparam logic [TimerW-1:0]    TRIPLE_RST   = 16'd500;

    // Tap count threshold and saturation point
    localparam logic [TapW-1:0] TAP_TWO = 2'd2;
    localparam logic [TapW-1:0] TAP_MAX = 2'd3;

    typedef struct packed {
        logic [DebounceW-1:0] debounce_ticks;
        logic [TimerW-1:0]    long_press_ticks;
        logic [TimerW-1:0]    double_window_ticks;
        logic [TimerW-1:0]    triple_window_ticks;
    } t_cfg;

endpackage

[hdl/bgd_ifs.sv]
// Stream interfaces for the button level items and the gesture result items.
`timescale 1ns / 1ps

interface bgd_in_if;
    logic valid;
    logic ready;
    logic button_pressed;

    modport source (output valid, output button_pressed, input ready);
    modport sink   (input valid, input button_pressed, output ready);
endinterface

interface bgd_out_if;
    logic                          valid;
    logic                          ready;
    logic [bgd_pkg::GestureW-1:0]  gesture;

    modport source (output valid, output gesture, input ready);
    modport sink   (input valid, input gesture, output ready);
endinterface

[hdl/bgd_cfg_regs.sv]
// Configuration register bank for the gesture detector timings.
`timescale 1ns / 1ps

module bgd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bgd_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [bgd_pkg::CfgDataW-1:0]  i_cfg_data,
    output bgd_pkg::t_cfg                 o_cfg
);

    bgd_pkg::t_cfg r_cfg;
    bgd_pkg::t_cfg n_cfg;

    // Decode the write; data is truncated to each register's width
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                bgd_pkg::REG_DEBOUNCE:
                    n_cfg.debounce_ticks = i_cfg_data[bgd_pkg::DebounceW-1:0];
                bgd_pkg::REG_LONG:   n_cfg.long_press_ticks    = i_cfg_data;
                bgd_pkg::REG_DOUBLE: n_cfg.double_window_ticks = i_cfg_data;
                bgd_pkg::REG_TRIPLE: n_cfg.triple_window_ticks = i_cfg_data;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks      <= bgd_pkg::DEBOUNCE_RST;
            r_cfg.long_press_ticks    <= bgd_pkg::LONG_RST;
            r_cfg.double_window_ticks <= bgd_pkg::DOUBLE_RST;
            r_cfg.triple_window_ticks <= bgd_pkg::TRIPLE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/bgd_core.sv]
// Gesture state machine: mode, timers and tap count, one update per item.
`timescale 1ns / 1ps

module bgd_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bgd_pkg::t_cfg                 i_cfg,
    input  logic                          i_step,
    input  logic                          i_level,
    output logic [bgd_pkg::GestureW-1:0]  o_gesture
);

    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_PRESSED  = 2'd1;
    localparam logic [1:0] MODE_WAITING  = 2'd2;
    localparam logic [1:0] MODE_DEBOUNCE = 2'd3;

    localparam logic [bgd_pkg::TimerW-1:0] TIMER_MAX = '1;

    logic [1:0]                   r_mode,  n_mode;
    logic                         r_from_wait, n_from_wait;
    logic [bgd_pkg::TimerW-1:0]   r_press, n_press;
    logic [bgd_pkg::TimerW-1:0]   r_rel,   n_rel;
    logic [bgd_pkg::TapW-1:0]     r_tap,   n_tap;

    logic [bgd_pkg::TimerW-1:0]   press_inc;
    logic [bgd_pkg::TimerW-1:0]   rel_inc;
    logic [bgd_pkg::TimerW-1:0]   window;
    logic [bgd_pkg::TimerW-1:0]   debounce_ext;
    logic                         debounce_zero;
    logic [bgd_pkg::GestureW-1:0] gesture;

    // Saturating timer increments and window selection
    assign press_inc     = (r_press == TIMER_MAX) ? TIMER_MAX : r_press + 1'b1;
    assign rel_inc       = (r_rel == TIMER_MAX) ? TIMER_MAX : r_rel + 1'b1;
    assign window        = (r_tap >= bgd_pkg::TAP_TWO) ? i_cfg.triple_window_ticks
                                                       : i_cfg.double_window_ticks;
    assign debounce_ext  = {{(bgd_pkg::TimerW-bgd_pkg::DebounceW){1'b0}},
                            i_cfg.debounce_ticks};
    assign debounce_zero = (i_cfg.debounce_ticks == '0);

    // Next state for one item
    always_comb begin
        n_mode      = r_mode;
        n_from_wait = r_from_wait;
        n_press     = r_press;
        n_rel       = r_rel;
        n_tap       = r_tap;
        gesture     = bgd_pkg::GEST_NONE;
        case (r_mode)
            MODE_IDLE: begin
                if (i_level) begin
                    n_from_wait = 1'b0;
                    n_press     = '0;
                    n_mode      = debounce_zero ? MODE_PRESSED : MODE_DEBOUNCE;
                end
            end
            MODE_PRESSED: begin
                if (!i_level) begin
                    if (r_tap != bgd_pkg::TAP_MAX) n_tap = r_tap + 1'b1;
                    n_rel  = '0;
                    n_mode = MODE_WAITING;
                end else begin
                    n_press = press_inc;
                    if (press_inc >= i_cfg.long_press_ticks) begin
                        n_tap   = '0;
                        n_mode  = MODE_IDLE;
                        gesture = bgd_pkg::GEST_LONG;
                    end
                end
            end
            MODE_WAITING: begin
                if (i_level) begin
                    n_from_wait = 1'b1;
                    n_press     = '0;
                    n_mode      = debounce_zero ? MODE_PRESSED : MODE_DEBOUNCE;
                end else begin
                    n_rel = rel_inc;
                    if (rel_inc >= window) begin
                        if (r_tap == bgd_pkg::TAP_TWO)      gesture = bgd_pkg::GEST_DOUBLE;
                        else if (r_tap == bgd_pkg::TAP_MAX) gesture = bgd_pkg::GEST_TRIPLE;
                        n_tap  = '0;
                        n_mode = MODE_IDLE;
                    end
                end
            end
            default: begin
                // Debouncing: the window keeps running when we came from waiting
                n_press = press_inc;
                if (r_from_wait) n_rel = rel_inc;
                if (press_inc >= debounce_ext) begin
                    if (i_level) begin
                        n_mode  = MODE_PRESSED;
                        n_press = '0;
                    end else begin
                        n_mode = r_from_wait ? MODE_WAITING : MODE_IDLE;
                    end
                end
            end
        endcase
    end

    // State registers advance only when an item is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_from_wait <= 1'b0;
            r_press     <= '0;
            r_rel       <= '0;
            r_tap       <= '0;
        end else if (i_step) begin
            r_mode      <= n_mode;
            r_from_wait <= n_from_wait;
            r_press     <= n_press;
            r_rel       <= n_rel;
            r_tap       <= n_tap;
        end
    end

    assign o_gesture = gesture;

    // Any reported gesture ends in idle with the taps cleared
    a_gesture_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && gesture != bgd_pkg::GEST_NONE) |=> (r_mode == MODE_IDLE && r_tap == '0))
        else $error("gesture did not return to idle with taps cleared");

    // No item, no state change
    a_hold_without_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_mode) && $stable(r_tap) && $stable(r_press) && $stable(r_rel)))
        else $error("state changed without an item");

    // Double and triple taps only come out of the window
    a_taps_from_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (gesture == bgd_pkg::GEST_DOUBLE || gesture == bgd_pkg::GEST_TRIPLE)
        |-> (r_mode == MODE_WAITING && r_tap >= bgd_pkg::TAP_TWO))
        else $error("tap gesture outside the release window");

    // A release from pressed always counts at least one tap
    a_release_counts_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_mode == MODE_PRESSED && !i_level) |=> (r_tap != '0 && r_rel == '0))
        else $error("release did not register a tap");

endmodule

[hdl/button_gesture_detector.sv]
// Top level of the button gesture detector: input register, state update, result register.
//
//  channel   dir   handshake       payload
//  i_in      in    valid/ready     button_pressed (1 bit)
//  o_out     out   valid/ready     gesture (2 bit)
//  i_cfg_*   in    write enable    i_cfg_idx (2 bit), i_cfg_data (16 bit)
//
// One item per clock sustained while o_out is ready; each item passes through the input
// register, then the state update feeding the result register, before it shows on o_out.
// Every accepted item gives exactly one result item.
// Reset is synchronous, active low; it restores idle state and default timings.
// A stall on o_out holds the result register and, once the input register is full,
// drops i_in.ready.
`timescale 1ns / 1ps

module button_gesture_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bgd_in_if.sink                        i_in,
    bgd_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [bgd_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [bgd_pkg::CfgDataW-1:0]  i_cfg_data
);

    bgd_pkg::t_cfg                cfg;
    logic                         r_in_valid;
    logic                         r_in_level;
    logic                         r_out_valid;
    logic [bgd_pkg::GestureW-1:0] r_out_gesture;
    logic [bgd_pkg::GestureW-1:0] gesture;
    logic                         out_load;
    logic                         step;

    bgd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Pipeline flow control
    assign out_load   = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && out_load;
    assign i_in.ready = !r_in_valid || out_load;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_level <= i_in.button_pressed;
        end
    end

    bgd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_step    (step),
        .i_level   (r_in_level),
        .o_gesture (gesture)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_gesture <= gesture;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.gesture = r_out_gesture;

endmodule
